/* src/eeb_pkg.sv */
// Shared widths, types and controller encodings for the extended Euclid block.
`timescale 1ns / 1ps
package eeb_pkg;

  localparam int WIDTH = 32;
  localparam int CW    = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0]        word_t;
  typedef logic signed [CW-1:0]    coef_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mul;
    logic update;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic r1_zero;
    logic div_last;
  } sts_t;

endpackage

/* src/eeb_ifs.sv */
// Operand and result channel interfaces for the extended Euclid block.
`timescale 1ns / 1ps
interface eeb_in_if import eeb_pkg::*; ;
  logic  valid;
  logic  ready;
  word_t operand_a;
  word_t operand_b;

  modport source (output valid, operand_a, operand_b, input ready);
  modport sink   (input valid, operand_a, operand_b, output ready);
endinterface

interface eeb_out_if import eeb_pkg::*; ;
  logic  valid;
  logic  ready;
  coef_t coef_a;
  coef_t coef_b;
  word_t divisor;

  modport source (output valid, coef_a, coef_b, divisor, input ready);
  modport sink   (input valid, coef_a, coef_b, divisor, output ready);
endinterface

/* src/eeb_ctrl.sv */
// Controller state machine sequencing the Euclid steps and the result register.
`timescale 1ns / 1ps
module eeb_ctrl import eeb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.r1_zero) begin
          if (slot_free) begin
            cmd.publish = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

/* src/eeb_dp.sv */
// Datapath: remainder pair, coefficient pairs, serial divider and result register.
`timescale 1ns / 1ps
module eeb_dp import eeb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  output sts_t  sts,
  input  word_t operand_a,
  input  word_t operand_b,
  output coef_t coef_a,
  output coef_t coef_b,
  output word_t divisor
);

  word_t r0_r, r1_r;
  coef_t s0_r, s1_r, t0_r, t1_r;
  coef_t ps_r, pt_r;
  word_t quo_r, rem_r;
  cnt_t  cnt_r;
  coef_t coef_a_r, coef_b_r;
  word_t divisor_r;

  logic [WIDTH:0]      rem_sh;
  logic [WIDTH:0]      diff;
  logic [WIDTH+CW-1:0] ps_full, pt_full;

  assign rem_sh  = {rem_r, quo_r[WIDTH-1]};
  assign diff    = rem_sh - {1'b0, r1_r};
  assign ps_full = {{CW{1'b0}}, quo_r} * {{WIDTH{1'b0}}, s1_r};
  assign pt_full = {{CW{1'b0}}, quo_r} * {{WIDTH{1'b0}}, t1_r};

  assign sts.r1_zero  = (r1_r == '0);
  assign sts.div_last = (cnt_r == CNT_W'(WIDTH - 1));

  // cnt_r is only read while dividing, after div_init has set it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_init) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0_r <= operand_a;
      r1_r <= operand_b;
      s0_r <= CW'(1);
      s1_r <= '0;
      t0_r <= '0;
      t1_r <= CW'(1);
    end else if (cmd.update) begin
      r0_r <= r1_r;
      r1_r <= rem_r;
      s0_r <= s1_r;
      s1_r <= s0_r - ps_r;
      t0_r <= t1_r;
      t1_r <= t0_r - pt_r;
    end
  end

  // restoring division: one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= r0_r;
    end else if (cmd.div_step) begin
      if (!diff[WIDTH]) begin
        rem_r <= diff[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ps_r <= ps_full[CW-1:0];
      pt_r <= pt_full[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      coef_a_r  <= s0_r;
      coef_b_r  <= t0_r;
      divisor_r <= r0_r;
    end
  end

  assign coef_a  = coef_a_r;
  assign coef_b  = coef_b_r;
  assign divisor = divisor_r;

endmodule

/* src/extended_euclid_bezout.sv */
// Top level of the extended Euclid block: gcd with Bezout coefficients.
//
//  channel | role   | payload                        | handshake
//  --------+--------+--------------------------------+-------------
//  in_if   | sink   | operand_a, operand_b (32 b)    | valid/ready
//  out_if  | source | coef_a, coef_b (33 b), divisor | valid/ready
//
// Each Euclid step passes the check, divide, multiply and update states, the
// divide state running the bit-serial divider; 32-bit operands need up to
// 46 steps. in_if.ready is high only while the block is idle.
// The result register frees the block: a new operand pair is taken while a
// result still waits; a finished result waits only if that register is full.
// rst_n is synchronous and clears the controller and the result valid.
`timescale 1ns / 1ps
module extended_euclid_bezout import eeb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  eeb_in_if.sink    in_if,
  eeb_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  eeb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eeb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .operand_a (in_if.operand_a),
    .operand_b (in_if.operand_b),
    .coef_a    (out_if.coef_a),
    .coef_b    (out_if.coef_b),
    .divisor   (out_if.divisor)
  );

endmodule

/* src/eeb_chk.sv */
// Port-level assertions for the extended Euclid block, bound to the top level.
`timescale 1ns / 1ps
module eeb_chk import eeb_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input coef_t coef_a,
  input coef_t coef_b,
  input word_t divisor
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(coef_a) && $stable(coef_b)
      && $stable(divisor))
    else $error("stalled result changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

  a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divisor == '0 |-> coef_a == CW'(1) && coef_b == '0)
    else $error("zero divisor without coefficients one and zero");

endmodule

bind extended_euclid_bezout eeb_chk u_eeb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .coef_a    (out_if.coef_a),
  .coef_b    (out_if.coef_b),
  .divisor   (out_if.divisor)
);

/* test/tb_extended_euclid_bezout.sv */
// Self-checking testbench for the extended Euclid block: gcd and Bezout coefficients.
`timescale 1ns / 1ps
module tb_extended_euclid_bezout;
  import eeb_pkg::*;

  typedef struct {
    word_t op_a;
    word_t op_b;
    coef_t coef_a;
    coef_t coef_b;
    word_t divisor;
  } bezout_t;

  logic clk;
  logic rst_n;

  eeb_in_if  in_if();
  eeb_out_if out_if();

  extended_euclid_bezout dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  bezout_t bezout_q[$];
  int      mismatch_count = 0;
  int      pairs_sent     = 0;
  int      results_seen   = 0;
  bit      tx_no_gaps     = 0;
  bit      rx_no_stalls   = 0;
  int      rx_hold_req    = 0;
  int      rx_stall       = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bezout_t predict_bezout(word_t a, word_t b);
    logic [63:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur, quot, nxt;
    bezout_t     res;
    r_prev = 64'(a);
    r_cur  = 64'(b);
    s_prev = 64'd1;
    s_cur  = 64'd0;
    t_prev = 64'd0;
    t_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quot   = r_prev / r_cur;
      nxt    = r_prev - quot * r_cur;
      r_prev = r_cur;
      r_cur  = nxt;
      nxt    = s_prev - quot * s_cur;
      s_prev = s_cur;
      s_cur  = nxt;
      nxt    = t_prev - quot * t_cur;
      t_prev = t_cur;
      t_cur  = nxt;
    end
    res.op_a    = a;
    res.op_b    = b;
    res.coef_a  = s_prev[CW-1:0];
    res.coef_b  = t_prev[CW-1:0];
    res.divisor = r_prev[WIDTH-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
    return $urandom_range(30, 150);
  endfunction

  function automatic word_t width_mask(int bits);
    return word_t'((64'd1 << bits) - 64'd1);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_pair(word_t a, word_t b);
    int gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk); while (!in_if.ready);
    bezout_q.insert(bezout_q.size(), predict_bezout(a, b));
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic sender_idle();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_result_ready
    if (rx_hold_req > 0) begin
      rx_stall    = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall > 0) begin
      out_if.ready <= 1'b0;
      rx_stall--;
    end else if (!rx_no_stalls && $urandom_range(0, 15) == 0) begin
      out_if.ready <= 1'b0;
      rx_stall = pick_stall() - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    bezout_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (bezout_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d g=%0h",
                                  out_if.coef_a, out_if.coef_b, out_if.divisor));
      end else begin
        exp_r = bezout_q.pop_front();
        if (out_if.coef_a !== exp_r.coef_a)
          report_mismatch($sformatf("coef_a %0d, want %0d for a=%0h b=%0h",
                                    out_if.coef_a, exp_r.coef_a, exp_r.op_a, exp_r.op_b));
        if (out_if.coef_b !== exp_r.coef_b)
          report_mismatch($sformatf("coef_b %0d, want %0d for a=%0h b=%0h",
                                    out_if.coef_b, exp_r.coef_b, exp_r.op_a, exp_r.op_b));
        if (out_if.divisor !== exp_r.divisor)
          report_mismatch($sformatf("divisor %0h, want %0h for a=%0h b=%0h",
                                    out_if.divisor, exp_r.divisor, exp_r.op_a, exp_r.op_b));
      end
    end
  end

  task automatic test_directed();
    word_t dir_a [21] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                          32'd2971215073, 32'd1836311903, 32'h8000_0000, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'd12, 32'd240, 32'd7, 32'h1, 32'd4294967291,
                          32'h8000_0000};
    word_t dir_b [21] = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF,
                          32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                          32'd1836311903, 32'd2971215073, 32'h4000_0000, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'd18, 32'd46, 32'd7, 32'h1, 32'd65537,
                          32'h7FFF_FFFF};
    for (int i = 0; i < 21; i++) send_pair(dir_a[i], dir_b[i]);
  endtask

  task automatic test_random_wide(int n);
    for (int i = 0; i < n; i++) send_pair(word_t'($urandom), word_t'($urandom));
  endtask

  task automatic test_shared_factors(int n);
    word_t g, x, y;
    for (int i = 0; i < n; i++) begin
      g = word_t'($urandom_range(1, (i % 4 == 0) ? 32'hFFFF : 32'hFF));
      x = word_t'($urandom_range(0, 32'hFFFF_FFFF / g));
      y = word_t'($urandom_range(0, 32'hFFFF_FFFF / g));
      send_pair(g * x, g * y);
    end
  endtask

  task automatic test_mixed_widths(int n);
    word_t a, b;
    for (int i = 0; i < n; i++) begin
      a = word_t'($urandom) & width_mask($urandom_range(1, WIDTH));
      b = word_t'($urandom) & width_mask($urandom_range(1, WIDTH));
      if ($urandom_range(0, 9) == 0) a = '0;
      if ($urandom_range(0, 9) == 0) b = '0;
      send_pair(a, b);
    end
  endtask

  // consecutive Fibonacci numbers give the longest quotient chains
  task automatic test_long_chains(int n);
    longint unsigned fib [48];
    longint unsigned m;
    int              k;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 48; i++) fib[i] = fib[i-1] + fib[i-2];
    rx_no_stalls = 1;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(2, 47);
      m = 64'($urandom_range(1, 32'(64'hFFFF_FFFF / fib[k])));
      if ($urandom_range(0, 1) == 0) send_pair(word_t'(fib[k] * m), word_t'(fib[k-1] * m));
      else send_pair(word_t'(fib[k-1] * m), word_t'(fib[k] * m));
    end
    rx_no_stalls = 0;
  endtask

  // hold the result side so the block fills and stalls its input
  task automatic test_output_backpressure(int n);
    tx_no_gaps  = 1;
    rx_hold_req = 2500;
    for (int i = 0; i < n; i++)
      send_pair(word_t'($urandom_range(0, 255)), word_t'($urandom_range(0, 255)));
    tx_no_gaps = 0;
  endtask

  task automatic test_drain_pause(int n);
    for (int i = 0; i < n; i++) begin
      send_pair(word_t'($urandom) & width_mask($urandom_range(1, WIDTH)), word_t'($urandom));
      if (i == n / 2) begin
        sender_idle();
        while (bezout_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end
    end
  endtask

  initial begin : run_tests
    int waited;
    in_if.valid     = 1'b0;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_wide(140);
    test_shared_factors(80);
    test_output_backpressure(10);
    test_mixed_widths(80);
    test_long_chains(20);
    test_drain_pause(20);

    sender_idle();
    waited = 0;
    while (bezout_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (2000) @(negedge clk);
    if (bezout_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", bezout_q.size()));

    $display("Sent %0d operand pairs, checked %0d results, %0d mismatches", pairs_sent,
             results_seen, mismatch_count);
    $display("Covered zero operands, extremes, shared factors, Fibonacci chains and stalls");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
